>>> rtl/shralu_pkg.sv
// Shared types and codes for the shifted-register ALU.
package shralu_pkg;

	localparam int unsigned DataWidth   = 64;
	localparam int unsigned NarrowWidth = 32;
	localparam int unsigned AmountWidth = 6;

	// Instruction class
	localparam logic CMD_LOGICAL = 1'b0;
	localparam logic CMD_ARITH   = 1'b1;

	// Logical opcodes
	localparam logic [1:0] LOG_AND  = 2'd0;
	localparam logic [1:0] LOG_ORR  = 2'd1;
	localparam logic [1:0] LOG_EOR  = 2'd2;
	localparam logic [1:0] LOG_ANDS = 2'd3;

	// Bit positions within an add/subtract opcode
	localparam int unsigned OPC_SUB_BIT  = 1;
	localparam int unsigned OPC_FLAG_BIT = 0;

	// Shift types
	localparam logic [1:0] SHIFT_LSL = 2'd0;
	localparam logic [1:0] SHIFT_LSR = 2'd1;
	localparam logic [1:0] SHIFT_ASR = 2'd2;
	localparam logic [1:0] SHIFT_ROR = 2'd3;

	typedef struct packed {
		logic                   command;
		logic [1:0]             opcode;
		logic                   invert_second;
		logic                   wide_mode;
		logic [1:0]             shift_kind;
		logic [AmountWidth-1:0] shift_amount;
		logic [DataWidth-1:0]   first_operand;
		logic [DataWidth-1:0]   second_operand;
	} op_item_t;

	typedef struct packed {
		logic [DataWidth-1:0] result_value;
		logic                 flags_written;
		logic                 flag_negative;
		logic                 flag_zero;
		logic                 flag_carry;
		logic                 flag_overflow;
		logic                 reserved_encoding;
	} res_item_t;

endpackage

>>> rtl/shifted_register_alu.sv
// Top level of the shifted-register ALU: a four-stage pipeline.
//
// Executes one logical or add/subtract instruction of the shifted-register
// class per transfer. An instruction enters on op_item and its result leaves
// on res_item after passing through all four stages: stage 1 decodes and
// masks the operands to the operation width, stage 2 runs the barrel shifter
// and the inversion of the second operand, stage 3 runs the 64-bit adder or
// the bitwise unit, stage 4 forms the NZCV flags and holds the result for
// the receiver. One instruction is taken in every cycle while op_stall is low;
// res_valid rises when the instruction has been registered into stage 4, and
// the result leaves once res_stall is low. Each stage holds its contents
// while the next is full and cannot move; an empty stage still loads, so
// res_stall squeezes out bubbles and op_stall rises only once all four
// stages are full.
// Reserved encodings (rotate on add/subtract, or a 32-bit shift above 31)
// are flagged on reserved_encoding and still computed.
module shifted_register_alu (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    op_valid,
	output logic                    op_stall,
	input  shralu_pkg::op_item_t    op_item,
	output logic                    res_valid,
	input  logic                    res_stall,
	output shralu_pkg::res_item_t   res_item
);
	import shralu_pkg::*;

	localparam int unsigned TopWide   = DataWidth - 1;
	localparam int unsigned TopNarrow = NarrowWidth - 1;

	// Stage advance: a stage loads when it is empty or its contents move on
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	// ---------------------------------------------------------------- stage 1
	logic                   valid_s1;
	logic                   cmd_s1;
	logic [1:0]             opc_s1;
	logic                   inv_s1;
	logic                   wide_s1;
	logic [1:0]             stype_s1;
	logic [AmountWidth-1:0] amt_s1;
	logic [DataWidth-1:0]   a_s1;
	logic [DataWidth-1:0]   b_s1;
	logic                   rsv_s1;

	logic [DataWidth-1:0]   in_mask;
	logic [AmountWidth-1:0] in_amt;
	logic                   in_rsv;

	always_comb begin
		in_mask = op_item.wide_mode ? {DataWidth{1'b1}}
			: {{(DataWidth-NarrowWidth){1'b0}}, {NarrowWidth{1'b1}}};
		// narrow operations use only the low five bits of the amount
		in_amt  = op_item.wide_mode ? op_item.shift_amount
			: {1'b0, op_item.shift_amount[AmountWidth-2:0]};
		in_rsv  = (!op_item.wide_mode && op_item.shift_amount[AmountWidth-1])
			|| (op_item.command == CMD_ARITH && op_item.shift_kind == SHIFT_ROR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && op_valid) begin
			cmd_s1   <= op_item.command;
			opc_s1   <= op_item.opcode;
			inv_s1   <= op_item.invert_second;
			wide_s1  <= op_item.wide_mode;
			stype_s1 <= op_item.shift_kind;
			amt_s1   <= in_amt;
			a_s1     <= op_item.first_operand & in_mask;
			b_s1     <= op_item.second_operand & in_mask;
			rsv_s1   <= in_rsv;
		end
	end

	// ---------------------------------------------------------------- stage 2
	logic                 valid_s2;
	logic                 cmd_s2;
	logic [1:0]           opc_s2;
	logic                 wide_s2;
	logic [DataWidth-1:0] a_s2;
	logic [DataWidth-1:0] bb_s2;
	logic                 sub_s2;
	logic                 rsv_s2;

	logic [DataWidth-1:0]   s1_mask;
	logic                   s1_sign;
	logic [DataWidth-1:0]   b_sext;
	logic [DataWidth-1:0]   asr_full;
	logic [2*DataWidth-1:0] b_double;
	logic [2*DataWidth-1:0] ror_full;
	logic [DataWidth-1:0]   shifted;
	logic                   s1_sub;
	logic                   s1_flip;

	always_comb begin
		s1_mask  = wide_s1 ? {DataWidth{1'b1}}
			: {{(DataWidth-NarrowWidth){1'b0}}, {NarrowWidth{1'b1}}};
		s1_sign  = wide_s1 ? b_s1[TopWide] : b_s1[TopNarrow];
		b_sext   = wide_s1 ? b_s1
			: {{(DataWidth-NarrowWidth){s1_sign}}, b_s1[NarrowWidth-1:0]};
		// shift on its own so the sign fill is kept before masking
		asr_full = $signed(b_sext) >>> amt_s1;
		// doubled word for the rotate: the low half of the shift is the result
		b_double = wide_s1 ? {b_s1, b_s1}
			: {{DataWidth{1'b0}}, b_s1[NarrowWidth-1:0], b_s1[NarrowWidth-1:0]};
		ror_full = b_double >> amt_s1;
		case (stype_s1)
			SHIFT_LSL: shifted = (b_s1 << amt_s1) & s1_mask;
			SHIFT_LSR: shifted = b_s1 >> amt_s1;
			SHIFT_ASR: shifted = asr_full & s1_mask;
			SHIFT_ROR: shifted = ror_full[DataWidth-1:0] & s1_mask;
			default:   shifted = b_s1;
		endcase
		s1_sub  = (cmd_s1 == CMD_ARITH) && opc_s1[OPC_SUB_BIT];
		s1_flip = (cmd_s1 == CMD_LOGICAL) ? inv_s1 : s1_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			cmd_s2  <= cmd_s1;
			opc_s2  <= opc_s1;
			wide_s2 <= wide_s1;
			a_s2    <= a_s1;
			bb_s2   <= s1_flip ? (~shifted & s1_mask) : shifted;
			sub_s2  <= s1_sub;
			rsv_s2  <= rsv_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3
	logic                 valid_s3;
	logic                 wide_s3;
	logic                 arith_s3;
	logic                 setf_s3;
	logic [DataWidth-1:0] res_s3;
	logic                 carry_s3;
	logic                 atop_s3;
	logic                 bbtop_s3;
	logic                 rsv_s3;

	logic [DataWidth-1:0] s2_mask;
	logic [DataWidth:0]   sum;
	logic [DataWidth-1:0] s2_res;
	logic                 s2_carry;
	logic                 s2_setf;

	always_comb begin
		s2_mask = wide_s2 ? {DataWidth{1'b1}}
			: {{(DataWidth-NarrowWidth){1'b0}}, {NarrowWidth{1'b1}}};
		sum     = {1'b0, a_s2} + {1'b0, bb_s2} + {{DataWidth{1'b0}}, sub_s2};
		// narrow operands sit below bit 32, so bit 32 of the sum is the carry
		s2_carry = wide_s2 ? sum[DataWidth] : sum[NarrowWidth];
		if (cmd_s2 == CMD_ARITH) begin
			s2_res  = sum[DataWidth-1:0] & s2_mask;
			s2_setf = opc_s2[OPC_FLAG_BIT];
		end else begin
			case (opc_s2)
				LOG_ORR: s2_res = a_s2 | bb_s2;
				LOG_EOR: s2_res = a_s2 ^ bb_s2;
				default: s2_res = a_s2 & bb_s2;
			endcase
			s2_setf = (opc_s2 == LOG_ANDS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			wide_s3  <= wide_s2;
			arith_s3 <= (cmd_s2 == CMD_ARITH);
			setf_s3  <= s2_setf;
			res_s3   <= s2_res;
			carry_s3 <= s2_carry;
			atop_s3  <= wide_s2 ? a_s2[TopWide] : a_s2[TopNarrow];
			bbtop_s3 <= wide_s2 ? bb_s2[TopWide] : bb_s2[TopNarrow];
			rsv_s3   <= rsv_s2;
		end
	end

	// ---------------------------------------------------------------- stage 4
	logic      valid_s4;
	logic      wide_s4;
	res_item_t item_s4;

	logic      res_top;
	res_item_t s3_item;

	always_comb begin
		res_top = wide_s3 ? res_s3[TopWide] : res_s3[TopNarrow];
		s3_item.result_value      = res_s3;
		s3_item.flags_written     = setf_s3;
		s3_item.flag_negative     = setf_s3 && res_top;
		s3_item.flag_zero         = setf_s3 && (res_s3 == '0);
		// carry and overflow only come from the adder
		s3_item.flag_carry        = setf_s3 && arith_s3 && carry_s3;
		s3_item.flag_overflow     = setf_s3 && arith_s3
			&& ((atop_s3 ^ res_top) && (bbtop_s3 ^ res_top));
		s3_item.reserved_encoding = rsv_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && valid_s3) begin
			item_s4 <= s3_item;
			wide_s4 <= wide_s3;
		end
	end

	// ------------------------------------------------------- flow control
	// Advance a stage when it is empty or when its contents move on
	assign adv_s4 = !valid_s4 || !res_stall;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign op_stall  = !adv_s1;
	assign res_valid = valid_s4;
	assign res_item  = item_s4;

	// ------------------------------------------------------------ assertions
	// An empty first stage must never hold off a transfer
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !op_stall)
		else $error("op_stall raised with stage 1 empty");

	// Flags stay clear for instructions that do not write them
	a_flags_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.flags_written |->
			!(res_item.flag_negative || res_item.flag_zero
			|| res_item.flag_carry || res_item.flag_overflow))
		else $error("flag set on an instruction that does not write flags");

	// Narrow results are zero-extended
	a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !wide_s4 |-> res_item.result_value[DataWidth-1:NarrowWidth] == '0)
		else $error("32-bit result has upper bits set");

	// A stalled output stage keeps a full stage 3 from moving
	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && res_stall && valid_s3 |=> valid_s3 && $stable(res_s3))
		else $error("stage 3 moved while blocked");

endmodule
